// ----- hdl/agga_pkg.sv -----
// Shared constants and types for the affine-gap global alignment distance block.
// No dependencies; used by agga_sat_add and affine_gap_global_align_distance.
package agga_pkg;

    localparam int LEN_BITS   = 8;
    localparam int MAX_LEN    = 1 << LEN_BITS;
    localparam int CNT_BITS   = LEN_BITS + 1;
    localparam int SCORE_W    = 32;
    localparam int DIST_W     = 10;
    localparam int ADDR_W     = 4;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic [CNT_BITS-1:0]       cnt_t;

    // trace pointer codes
    localparam logic [1:0] PTR_MATCH    = 2'd0;
    localparam logic [1:0] PTR_MISMATCH = 2'd1;
    localparam logic [1:0] PTR_UP       = 2'd2;
    localparam logic [1:0] PTR_LEFT     = 2'd3;

    // register indexes
    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP_OPEN = 2'd2;
    localparam logic [1:0] REG_GAP_EXT  = 2'd3;

endpackage

// ----- hdl/agga_sat_add.sv -----
// Shared saturating score adder, reused by the fill sequencer in its init, row and cell states.
// Depends on agga_pkg.
module agga_sat_add (
    input  agga_pkg::score_t a,
    input  agga_pkg::score_t b,
    output agga_pkg::score_t sum
);

    logic signed [agga_pkg::SCORE_W:0] wide;

    assign wide = {a[agga_pkg::SCORE_W-1], a} + {b[agga_pkg::SCORE_W-1], b};

    always_comb
    begin
        if (wide[agga_pkg::SCORE_W] == wide[agga_pkg::SCORE_W-1])
        begin
            sum = wide[agga_pkg::SCORE_W-1:0];
        end
        else if (wide[agga_pkg::SCORE_W])
        begin
            sum = {1'b1, {(agga_pkg::SCORE_W-1){1'b0}}};
        end
        else
        begin
            sum = {1'b0, {(agga_pkg::SCORE_W-1){1'b1}}};
        end
    end

endmodule

// ----- hdl/affine_gap_global_align_distance.sv -----
// Top level: sequence loading, affine-gap score fill, traceback and result register.
// Depends on agga_pkg and agga_sat_add.
//
//  channel  | direction | handshake          | payload
//  input    | in        | in_valid/in_stall  | seq_select, symbol, symbol_valid, last
//  result   | out       | out_valid/out_stall| distance, overflow
//  config   | in        | APB psel/penable   | paddr, pwdata, prdata
//
// Symbols load one per cycle while idle. Once both sequences are closed: a start state, a
// border pass, then per row a setup state and per cell states RD and C1 to C8, summing
// through one shared saturating adder. Traceback alternates TBC and TBW up to the border.
// in_stall is high from closing the pair until the result is loaded.
// Reset is asynchronous; score and pointer memories need no clearing.
module affine_gap_global_align_distance (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        seq_select,
    input  logic [7:0]  symbol,
    input  logic        symbol_valid,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [agga_pkg::DIST_W-1:0] distance,
    output logic        overflow,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [agga_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_INIT  = 4'd2;
    localparam logic [3:0] ST_ROW   = 4'd3;
    localparam logic [3:0] ST_RD    = 4'd4;
    localparam logic [3:0] ST_C1    = 4'd5;
    localparam logic [3:0] ST_C2    = 4'd6;
    localparam logic [3:0] ST_C3    = 4'd7;
    localparam logic [3:0] ST_C4    = 4'd8;
    localparam logic [3:0] ST_C5    = 4'd9;
    localparam logic [3:0] ST_C6    = 4'd10;
    localparam logic [3:0] ST_C7    = 4'd11;
    localparam logic [3:0] ST_C8    = 4'd12;
    localparam logic [3:0] ST_TBC   = 4'd13;
    localparam logic [3:0] ST_TBW   = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    logic signed [7:0] match_reg, mismatch_reg, open_reg, ext_reg;
    agga_pkg::score_t  ext_s, open_s;

    logic [3:0]      state_reg;
    agga_pkg::cnt_t  row_len_reg, col_len_reg, i_reg, j_reg;
    agga_pkg::cnt_t  im1, jm1;
    logic [1:0]      ends_reg;
    logic            ovf_reg;
    logic [agga_pkg::DIST_W-1:0] dist_reg;

    agga_pkg::score_t bacc_reg, rb_reg, pb0_reg, diag_reg, left_reg, hgap_reg;
    agga_pkg::score_t t_reg, t2_reg, e_reg, f_reg, mm_reg;
    agga_pkg::score_t add_a, add_b, sum;
    agga_pkg::score_t s_val;
    logic [1:0]       ptr_val;

    logic [7:0] row_mem [agga_pkg::MAX_LEN];
    logic [7:0] col_mem [agga_pkg::MAX_LEN];
    agga_pkg::score_t pb_mem [agga_pkg::MAX_LEN];
    agga_pkg::score_t pv_mem [agga_pkg::MAX_LEN];
    logic [1:0] tr_mem [agga_pkg::MAX_LEN * agga_pkg::MAX_LEN];
    logic [7:0] row_q, col_q;
    agga_pkg::score_t pb_q, pv_q;
    logic [1:0] tr_q;

    logic in_xfer, cfg_wr, sel_closed, same;
    logic [1:0] sel_bit, ends_new;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign ext_s    = agga_pkg::score_t'(ext_reg);
    assign open_s   = agga_pkg::score_t'(open_reg);
    assign im1      = i_reg - agga_pkg::cnt_t'(1);
    assign jm1      = j_reg - agga_pkg::cnt_t'(1);
    assign sel_bit  = seq_select ? 2'b10 : 2'b01;
    assign sel_closed = |(ends_reg & sel_bit);
    assign ends_new = ends_reg | (last ? sel_bit : 2'b00);
    assign same     = (row_q == col_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg    <= 8'sd2;
            mismatch_reg <= -8'sd3;
            open_reg     <= -8'sd5;
            ext_reg      <= -8'sd2;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                agga_pkg::REG_MATCH:    match_reg    <= pwdata[7:0];
                agga_pkg::REG_MISMATCH: mismatch_reg <= pwdata[7:0];
                agga_pkg::REG_GAP_OPEN: open_reg     <= pwdata[7:0];
                agga_pkg::REG_GAP_EXT:  ext_reg      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            agga_pkg::REG_MATCH:    prdata = 32'(signed'(match_reg));
            agga_pkg::REG_MISMATCH: prdata = 32'(signed'(mismatch_reg));
            agga_pkg::REG_GAP_OPEN: prdata = 32'(signed'(open_reg));
            agga_pkg::REG_GAP_EXT:  prdata = 32'(signed'(ext_reg));
            default:                prdata = 32'd0;
        endcase
    end

    // operand select for the shared adder
    always_comb
    begin
        add_a = hgap_reg;
        add_b = ext_s;
        case (state_reg)
            ST_INIT: begin add_a = bacc_reg; add_b = ext_s;  end
            ST_ROW:  begin add_a = rb_reg;   add_b = ext_s;  end
            ST_C1:   begin add_a = hgap_reg; add_b = ext_s;  end
            ST_C2:   begin add_a = left_reg; add_b = open_s; end
            ST_C3:   begin add_a = t2_reg;   add_b = ext_s;  end
            ST_C4:   begin add_a = pv_q;     add_b = ext_s;  end
            ST_C5:   begin add_a = pb_q;     add_b = open_s; end
            ST_C6:   begin add_a = t2_reg;   add_b = ext_s;  end
            ST_C7:
            begin
                add_a = diag_reg;
                add_b = same ? agga_pkg::score_t'(match_reg)
                             : agga_pkg::score_t'(mismatch_reg);
            end
            default: ;
        endcase
    end

    agga_sat_add u_add (
        .a   (add_a),
        .b   (add_b),
        .sum (sum)
    );

    // best score and pointer, ties: diagonal, vertical, horizontal
    always_comb
    begin
        agga_pkg::score_t mf;
        mf    = (mm_reg >= f_reg) ? mm_reg : f_reg;
        s_val = (mf >= e_reg) ? mf : e_reg;
        if (s_val == mm_reg)
        begin
            ptr_val = same ? agga_pkg::PTR_MATCH : agga_pkg::PTR_MISMATCH;
        end
        else if (s_val == f_reg)
        begin
            ptr_val = agga_pkg::PTR_UP;
        end
        else
        begin
            ptr_val = agga_pkg::PTR_LEFT;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (in_xfer && !sel_closed && symbol_valid && !seq_select
            && row_len_reg < agga_pkg::cnt_t'(agga_pkg::MAX_LEN))
        begin
            row_mem[row_len_reg[agga_pkg::LEN_BITS-1:0]] <= symbol;
        end
        if (in_xfer && !sel_closed && symbol_valid && seq_select
            && col_len_reg < agga_pkg::cnt_t'(agga_pkg::MAX_LEN))
        begin
            col_mem[col_len_reg[agga_pkg::LEN_BITS-1:0]] <= symbol;
        end
        if (state_reg == ST_ROW)
        begin
            row_q <= row_mem[im1[agga_pkg::LEN_BITS-1:0]];
        end
        if (state_reg == ST_RD)
        begin
            col_q <= col_mem[jm1[agga_pkg::LEN_BITS-1:0]];
            pb_q  <= pb_mem[jm1[agga_pkg::LEN_BITS-1:0]];
            pv_q  <= pv_mem[jm1[agga_pkg::LEN_BITS-1:0]];
        end
        if (state_reg == ST_INIT)
        begin
            pb_mem[jm1[agga_pkg::LEN_BITS-1:0]] <= sum;
            pv_mem[jm1[agga_pkg::LEN_BITS-1:0]] <= sum;
        end
        if (state_reg == ST_C8)
        begin
            pb_mem[jm1[agga_pkg::LEN_BITS-1:0]] <= s_val;
            pv_mem[jm1[agga_pkg::LEN_BITS-1:0]] <= f_reg;
            tr_mem[{im1[agga_pkg::LEN_BITS-1:0], jm1[agga_pkg::LEN_BITS-1:0]}] <= ptr_val;
        end
        if (state_reg == ST_TBC)
        begin
            tr_q <= tr_mem[{im1[agga_pkg::LEN_BITS-1:0], jm1[agga_pkg::LEN_BITS-1:0]}];
        end
    end

    // working scores
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_START:
            begin
                bacc_reg <= open_s;
                rb_reg   <= open_s;
                pb0_reg  <= '0;
            end
            ST_INIT: bacc_reg <= sum;
            ST_ROW:
            begin
                rb_reg   <= sum;
                left_reg <= sum;
                hgap_reg <= sum;
                diag_reg <= pb0_reg;
                pb0_reg  <= sum;
            end
            ST_C1: t_reg  <= sum;
            ST_C2: t2_reg <= sum;
            ST_C3: e_reg  <= (t_reg >= sum) ? t_reg : sum;
            ST_C4: t_reg  <= sum;
            ST_C5: t2_reg <= sum;
            ST_C6: f_reg  <= (t_reg >= sum) ? t_reg : sum;
            ST_C7: mm_reg <= sum;
            ST_C8:
            begin
                diag_reg <= pb_q;
                left_reg <= s_val;
                hgap_reg <= e_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_len_reg <= '0;
            col_len_reg <= '0;
            ends_reg    <= '0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            dist_reg    <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && (!out_valid || !out_stall))
            begin
                out_valid <= 1'b1;
            end
            else if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer && !sel_closed)
                    begin
                        if (symbol_valid)
                        begin
                            if (!seq_select)
                            begin
                                if (row_len_reg < agga_pkg::cnt_t'(agga_pkg::MAX_LEN))
                                    row_len_reg <= row_len_reg + agga_pkg::cnt_t'(1);
                                else
                                    ovf_reg <= 1'b1;
                            end
                            else
                            begin
                                if (col_len_reg < agga_pkg::cnt_t'(agga_pkg::MAX_LEN))
                                    col_len_reg <= col_len_reg + agga_pkg::cnt_t'(1);
                                else
                                    ovf_reg <= 1'b1;
                            end
                        end
                        ends_reg <= ends_new;
                        if (ends_new == 2'b11)
                        begin
                            state_reg <= ST_START;
                        end
                    end
                end
                ST_START:
                begin
                    dist_reg <= '0;
                    j_reg    <= agga_pkg::cnt_t'(1);
                    i_reg    <= agga_pkg::cnt_t'(1);
                    if (row_len_reg == '0 || col_len_reg == '0)
                    begin
                        i_reg     <= row_len_reg;
                        j_reg     <= col_len_reg;
                        state_reg <= ST_TBC;
                    end
                    else
                    begin
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT:
                begin
                    if (j_reg == col_len_reg)
                    begin
                        state_reg <= ST_ROW;
                    end
                    else
                    begin
                        j_reg <= j_reg + agga_pkg::cnt_t'(1);
                    end
                end
                ST_ROW:
                begin
                    j_reg     <= agga_pkg::cnt_t'(1);
                    state_reg <= ST_RD;
                end
                ST_RD: state_reg <= ST_C1;
                ST_C1: state_reg <= ST_C2;
                ST_C2: state_reg <= ST_C3;
                ST_C3: state_reg <= ST_C4;
                ST_C4: state_reg <= ST_C5;
                ST_C5: state_reg <= ST_C6;
                ST_C6: state_reg <= ST_C7;
                ST_C7: state_reg <= ST_C8;
                ST_C8:
                begin
                    if (j_reg != col_len_reg)
                    begin
                        j_reg     <= j_reg + agga_pkg::cnt_t'(1);
                        state_reg <= ST_RD;
                    end
                    else if (i_reg != row_len_reg)
                    begin
                        i_reg     <= i_reg + agga_pkg::cnt_t'(1);
                        state_reg <= ST_ROW;
                    end
                    else
                    begin
                        state_reg <= ST_TBC;
                    end
                end
                ST_TBC:
                begin
                    if (i_reg == '0 || j_reg == '0)
                    begin
                        dist_reg  <= dist_reg + agga_pkg::DIST_W'(i_reg)
                                              + agga_pkg::DIST_W'(j_reg);
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_TBW;
                    end
                end
                ST_TBW:
                begin
                    if (tr_q != agga_pkg::PTR_MATCH)
                    begin
                        dist_reg <= dist_reg + agga_pkg::DIST_W'(1);
                    end
                    if (tr_q != agga_pkg::PTR_LEFT)
                    begin
                        i_reg <= im1;
                    end
                    if (tr_q != agga_pkg::PTR_UP)
                    begin
                        j_reg <= jm1;
                    end
                    state_reg <= ST_TBC;
                end
                ST_OUT:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        row_len_reg <= '0;
                        col_len_reg <= '0;
                        ends_reg    <= '0;
                        ovf_reg     <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result register, loaded on leaving ST_OUT
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!out_valid || !out_stall))
        begin
            distance <= dist_reg;
            overflow <= ovf_reg;
        end
    end

    a_cell_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_C8) |-> (j_reg != '0 && j_reg <= col_len_reg
                                  && i_reg != '0 && i_reg <= row_len_reg))
        else $error("fill cell index out of range");

    a_walk_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TBW) |-> (i_reg != '0 && j_reg != '0))
        else $error("traceback step at border");

    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |->
        (dist_reg <= agga_pkg::DIST_W'(row_len_reg) + agga_pkg::DIST_W'(col_len_reg)))
        else $error("distance exceeds total length");

    a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (ends_reg != 2'b11))
        else $error("both sequences closed while idle");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && (!out_valid || !out_stall)) |=>
        (out_valid && state_reg == ST_IDLE && ends_reg == '0))
        else $error("result transfer not set up");

endmodule
